// ===== hw/rtl/pspg_pkg.sv =====
package pspg_pkg;

    // coordinate width handled by the datapath
    localparam int COORD_BITS = 12;
    localparam int CENTER_W   = 12;
    localparam int EFF_W      = (COORD_BITS < CENTER_W) ? COORD_BITS : CENTER_W;

    localparam int HW_W   = 8;
    localparam int Q2_W   = 2 * HW_W;
    localparam int HEAD_W = HW_W + 1;
    localparam int SIDE_W = 14;
    localparam int TIME_W = 32;

    // squared step length, scaled component and its square
    localparam int D2_W  = 2 * EFF_W + 1;
    localparam int A_W   = EFF_W + HW_W;
    localparam int TGT_W = 2 * A_W;

    // shared multiplier operand widths
    localparam int MUL_A_W = (A_W > Q2_W) ? A_W : Q2_W;
    localparam int MUL_B_W = (D2_W > A_W) ? D2_W : A_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam int BIT_W = $clog2(HW_W);

    localparam logic [HW_W-1:0] HW_RESET = HW_W'(50);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQX,
        S_SQY,
        S_SCALE,
        S_TGT,
        S_SRCH,
        S_DONE
    } t_state;

endpackage

// ===== hw/rtl/path_side_point_generator_unit.sv =====
// Sequence per input transaction for a usable step: square the step (S_SQX, S_SQY);
//   per component scale (S_SCALE), form the target (S_TGT) and bit-search (S_SRCH); finish (S_DONE).
//   A step of length one or zero goes from S_SCALE to S_DONE; with no previous point, S_IDLE to S_DONE.
// Throughput: one point at a time; no new point is taken until the result is loaded out. The single
//   shared multiplier serialises the steps, and a result waiting on the output stalls the finish.
// Reset (i_rst_n low, synchronous): idle, no previous point, half-width 50, no result.
module path_side_point_generator_unit
    import pspg_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    // configuration: half-width
    input  logic                     i_cfg_wr_en,
    input  logic [HW_W-1:0]          i_cfg_wr_data,

    // input channel
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [CENTER_W-1:0]      i_center_x,
    input  logic [CENTER_W-1:0]      i_center_y,
    input  logic [TIME_W-1:0]        i_time_ms,
    input  logic                     i_restart,

    // output channel
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [CENTER_W-1:0]      o_out_center_x,
    output logic [CENTER_W-1:0]      o_out_center_y,
    output logic signed [SIDE_W-1:0] o_right_x,
    output logic signed [SIDE_W-1:0] o_right_y,
    output logic signed [SIDE_W-1:0] o_left_x,
    output logic signed [SIDE_W-1:0] o_left_y,
    output logic [TIME_W-1:0]        o_out_time_ms,
    output logic signed [HEAD_W-1:0] o_heading_x,
    output logic signed [HEAD_W-1:0] o_heading_y
);

    // ------------------------------------------------------------------
    // Control and state
    // ------------------------------------------------------------------
    t_state r_state, n_state;

    logic [HW_W-1:0]  r_half_width;
    logic [EFF_W-1:0] r_last_x, r_last_y;
    logic             r_have_last;

    // per-transaction working registers
    logic [EFF_W-1:0]  r_cx, r_cy;
    logic [TIME_W-1:0] r_time;
    logic [EFF_W-1:0]  r_mag_x, r_mag_y;
    logic              r_neg_x, r_neg_y;
    logic              r_comp;          // 0: x component, 1: y component
    logic [D2_W-1:0]   r_d2;
    logic [A_W-1:0]    r_a;
    logic [TGT_W-1:0]  r_tgt;
    logic [HW_W-1:0]   r_q;
    logic [Q2_W-1:0]   r_q2;
    logic [BIT_W-1:0]  r_bit;
    logic signed [HEAD_W-1:0] r_hx, r_hy;

    logic r_out_valid;

    logic w_in_acc;
    logic w_load_out;
    logic w_have_prev;

    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_have_prev = r_have_last && !i_restart;

    // ------------------------------------------------------------------
    // Step from the previous centre, sign and magnitude
    // ------------------------------------------------------------------
    logic [EFF_W-1:0] w_cx, w_cy;
    logic [EFF_W:0]   w_dx, w_dy, w_dx_abs, w_dy_abs;

    assign w_cx = i_center_x[EFF_W-1:0];
    assign w_cy = i_center_y[EFF_W-1:0];
    assign w_dx = {1'b0, w_cx} - {1'b0, r_last_x};
    assign w_dy = {1'b0, w_cy} - {1'b0, r_last_y};
    assign w_dx_abs = w_dx[EFF_W] ? (~w_dx + 1'b1) : w_dx;
    assign w_dy_abs = w_dy[EFF_W] ? (~w_dy + 1'b1) : w_dy;

    // ------------------------------------------------------------------
    // Shared multiplier
    // ------------------------------------------------------------------
    logic [MUL_A_W-1:0] w_mul_a;
    logic [MUL_B_W-1:0] w_mul_b;
    logic [PROD_W-1:0]  w_prod;
    logic [EFF_W-1:0]   w_mag_cur;
    logic               w_neg_cur;

    assign w_mag_cur = r_comp ? r_mag_y : r_mag_x;
    assign w_neg_cur = r_comp ? r_neg_y : r_neg_x;
    assign w_prod    = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);

    // ------------------------------------------------------------------
    // Bit search for one heading magnitude: largest q <= half-width with
    // q*q*d2 <= (|d|*half-width)^2. The candidate square is updated
    // incrementally: (q + 2^b)^2 = q^2 + q*2^(b+1) + 2^(2b).
    // ------------------------------------------------------------------
    logic [HW_W-1:0]   w_t;
    logic [Q2_W:0]     w_t2_wide;
    logic [Q2_W-1:0]   w_t2;
    logic              w_take;
    logic [HW_W-1:0]   w_q_next;
    logic [HEAD_W-1:0] w_qe;
    logic [HEAD_W-1:0] w_head;

    assign w_t       = r_q | (HW_W'(1) << r_bit);
    assign w_t2_wide = {1'b0, r_q2}
                     + (((Q2_W + 1)'(r_q) << r_bit) << 1)
                     + ((Q2_W + 1)'(1) << {r_bit, 1'b0});
    assign w_t2      = w_t2_wide[Q2_W-1:0];
    assign w_take    = (w_t <= r_half_width) && (w_prod <= PROD_W'(r_tgt));
    assign w_q_next  = w_take ? w_t : r_q;
    assign w_qe      = HEAD_W'(w_q_next);
    assign w_head    = w_neg_cur ? (~w_qe + 1'b1) : w_qe;

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = w_have_prev ? S_SQX : S_DONE;
                end
            end
            S_SQX:   n_state = S_SQY;
            S_SQY:   n_state = S_SCALE;
            S_SCALE: begin
                // a step of length one or zero keeps the default heading
                n_state = (r_d2 <= D2_W'(1)) ? S_DONE : S_TGT;
            end
            S_TGT:   n_state = S_SRCH;
            S_SRCH: begin
                if (r_bit == '0) begin
                    n_state = r_comp ? S_DONE : S_SCALE;
                end
            end
            S_DONE: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs (handshake and multiplier operands)
    // ------------------------------------------------------------------
    always_comb begin
        o_in_ready = 1'b0;
        w_load_out = 1'b0;
        w_mul_a    = '0;
        w_mul_b    = '0;
        case (r_state)
            S_IDLE:  o_in_ready = 1'b1;
            S_SQX: begin
                w_mul_a = MUL_A_W'(r_mag_x);
                w_mul_b = MUL_B_W'(r_mag_x);
            end
            S_SQY: begin
                w_mul_a = MUL_A_W'(r_mag_y);
                w_mul_b = MUL_B_W'(r_mag_y);
            end
            S_SCALE: begin
                w_mul_a = MUL_A_W'(w_mag_cur);
                w_mul_b = MUL_B_W'(r_half_width);
            end
            S_TGT: begin
                w_mul_a = MUL_A_W'(r_a);
                w_mul_b = MUL_B_W'(r_a);
            end
            S_SRCH: begin
                w_mul_a = MUL_A_W'(w_t2);
                w_mul_b = MUL_B_W'(r_d2);
            end
            S_DONE:  w_load_out = !r_out_valid || i_out_ready;
            default: o_in_ready = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_half_width <= HW_RESET;
            r_last_x     <= '0;
            r_last_y     <= '0;
            r_have_last  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_half_width <= i_cfg_wr_data;
            end
            if (w_in_acc) begin
                r_last_x    <= w_cx;
                r_last_y    <= w_cy;
                r_have_last <= 1'b1;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_cx    <= w_cx;
                    r_cy    <= w_cy;
                    r_time  <= i_time_ms;
                    r_mag_x <= w_dx_abs[EFF_W-1:0];
                    r_mag_y <= w_dy_abs[EFF_W-1:0];
                    r_neg_x <= w_dx[EFF_W];
                    r_neg_y <= w_dy[EFF_W];
                    r_comp  <= 1'b0;
                    r_hx    <= HEAD_W'(r_half_width);
                    r_hy    <= '0;
                end
            end
            S_SQX:   r_d2 <= D2_W'(w_prod);
            S_SQY:   r_d2 <= r_d2 + D2_W'(w_prod);
            S_SCALE: r_a  <= A_W'(w_prod);
            S_TGT: begin
                r_tgt <= TGT_W'(w_prod);
                r_q   <= '0;
                r_q2  <= '0;
                r_bit <= BIT_W'(HW_W - 1);
            end
            S_SRCH: begin
                r_q   <= w_q_next;
                r_bit <= r_bit - 1'b1;
                if (w_take) begin
                    r_q2 <= w_t2;
                end
                if (r_bit == '0) begin
                    if (r_comp) begin
                        r_hy <= w_head;
                    end else begin
                        r_hx <= w_head;
                    end
                    r_comp <= 1'b1;
                end
            end
            default: r_comp <= r_comp;
        endcase
    end

    // ------------------------------------------------------------------
    // Output register: side points are centre -/+ perpendicular
    // ------------------------------------------------------------------
    logic signed [SIDE_W-1:0] w_cx_s, w_cy_s, w_hx_s, w_hy_s;

    assign w_cx_s = SIDE_W'({1'b0, r_cx});
    assign w_cy_s = SIDE_W'({1'b0, r_cy});
    assign w_hx_s = SIDE_W'(r_hx);
    assign w_hy_s = SIDE_W'(r_hy);

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            o_out_center_x <= CENTER_W'(r_cx);
            o_out_center_y <= CENTER_W'(r_cy);
            o_right_x      <= w_cx_s - w_hy_s;
            o_right_y      <= w_cy_s + w_hx_s;
            o_left_x       <= w_cx_s + w_hy_s;
            o_left_y       <= w_cy_s - w_hx_s;
            o_out_time_ms  <= r_time;
            o_heading_x    <= r_hx;
            o_heading_y    <= r_hy;
        end
    end

    assign o_out_valid = r_out_valid;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_in_ready)
        else $error("input ready right after an accepted transaction");

    a_restart_skips_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_restart) |=> (r_state == S_DONE))
        else $error("restart point did not take the default heading");

    a_search_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH && r_bit == '0) |=> (r_state == S_SCALE || r_state == S_DONE))
        else $error("bit search did not finish after its last bit");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid)
        else $error("waiting result dropped");

endmodule

// ===== tb/sv/pspg_side_point_checker.sv =====
`timescale 1ns / 1ps

module pspg_side_point_checker
    import pspg_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    input  logic                     i_cfg_wr_en,
    input  logic [HW_W-1:0]          i_cfg_wr_data,

    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  logic [CENTER_W-1:0]      i_center_x,
    input  logic [CENTER_W-1:0]      i_center_y,
    input  logic [TIME_W-1:0]        i_time_ms,
    input  logic                     i_restart,

    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic [CENTER_W-1:0]      i_out_center_x,
    input  logic [CENTER_W-1:0]      i_out_center_y,
    input  logic signed [SIDE_W-1:0] i_right_x,
    input  logic signed [SIDE_W-1:0] i_right_y,
    input  logic signed [SIDE_W-1:0] i_left_x,
    input  logic signed [SIDE_W-1:0] i_left_y,
    input  logic [TIME_W-1:0]        i_out_time_ms,
    input  logic signed [HEAD_W-1:0] i_heading_x,
    input  logic signed [HEAD_W-1:0] i_heading_y,

    output int                       o_fail_count,
    output int                       o_pending
);

    typedef struct packed {
        logic [CENTER_W-1:0] cx;
        logic [CENTER_W-1:0] cy;
        logic [SIDE_W-1:0]   rx;
        logic [SIDE_W-1:0]   ry;
        logic [SIDE_W-1:0]   lx;
        logic [SIDE_W-1:0]   ly;
        logic [TIME_W-1:0]   t;
        logic [HEAD_W-1:0]   hx;
        logic [HEAD_W-1:0]   hy;
    } t_side_points;

    t_side_points        expected_points[$];
    t_side_points        exp_pt;
    t_side_points        act_pt;

    // predictor state
    logic [HW_W-1:0]     half_width;
    logic [CENTER_W-1:0] prev_x;
    logic [CENTER_W-1:0] prev_y;
    logic                have_prev;

    logic [CENTER_W-1:0] cx;
    logic [CENTER_W-1:0] cy;
    logic [HEAD_W-1:0]   hx;
    logic [HEAD_W-1:0]   hy;
    longint              dx;
    longint              dy;
    longint unsigned     d2;
    int                  result_idx;

    localparam logic [CENTER_W-1:0] COORD_MASK = CENTER_W'((1 << EFF_W) - 1);

    // largest q <= hw with q*q*d2 <= (|d|*hw)^2, sign of d applied
    function automatic logic [HEAD_W-1:0] scaled_heading(longint d, longint unsigned d2v,
                                                         longint unsigned hw);
        longint unsigned mag;
        longint unsigned goal;
        longint unsigned q;
        longint unsigned t;
        mag  = (d < 0) ? -d : d;
        goal = (mag * hw) * (mag * hw);
        q    = 0;
        for (int b = 7; b >= 0; b--) begin
            t = q | (64'd1 << b);
            if (t <= hw && t * t * d2v <= goal)
                q = t;
        end
        return (d < 0) ? -q[HEAD_W-1:0] : q[HEAD_W-1:0];
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        result_idx   = 0;
        half_width   = HW_RESET;
        prev_x       = '0;
        prev_y       = '0;
        have_prev    = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            half_width = HW_RESET;
            prev_x     = '0;
            prev_y     = '0;
            have_prev  = 1'b0;
            expected_points.delete();
        end else begin
            if (i_cfg_wr_en)
                half_width = i_cfg_wr_data;

            // result transaction: check against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                act_pt = '{i_out_center_x, i_out_center_y, i_right_x, i_right_y,
                           i_left_x, i_left_y, i_out_time_ms, i_heading_x, i_heading_y};
                if (expected_points.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    if (o_fail_count <= 10)
                        $display("%0t: unexpected result cx=%0d cy=%0d", $time,
                                 i_out_center_x, i_out_center_y);
                end else begin
                    exp_pt = expected_points.pop_front();
                    if (act_pt !== exp_pt) begin
                        o_fail_count = o_fail_count + 1;
                        if (o_fail_count <= 10) begin
                            $display("%0t: result %0d mismatch", $time, result_idx);
                            $display("  exp c=(%0d,%0d) r=(%0d,%0d) l=(%0d,%0d) t=%0d h=(%0d,%0d)",
                                     exp_pt.cx, exp_pt.cy, $signed(exp_pt.rx),
                                     $signed(exp_pt.ry), $signed(exp_pt.lx),
                                     $signed(exp_pt.ly), exp_pt.t, $signed(exp_pt.hx),
                                     $signed(exp_pt.hy));
                            $display("  act c=(%0d,%0d) r=(%0d,%0d) l=(%0d,%0d) t=%0d h=(%0d,%0d)",
                                     act_pt.cx, act_pt.cy, $signed(act_pt.rx),
                                     $signed(act_pt.ry), $signed(act_pt.lx),
                                     $signed(act_pt.ly), act_pt.t, $signed(act_pt.hx),
                                     $signed(act_pt.hy));
                        end
                    end
                end
                result_idx = result_idx + 1;
            end

            // point transaction: predict its side points
            if (i_in_valid && i_in_ready) begin
                cx = i_center_x & COORD_MASK;
                cy = i_center_y & COORD_MASK;
                if (i_restart)
                    have_prev = 1'b0;
                hx = HEAD_W'(half_width);
                hy = '0;
                if (have_prev) begin
                    dx = longint'(cx) - longint'(prev_x);
                    dy = longint'(cy) - longint'(prev_y);
                    d2 = dx * dx + dy * dy;
                    if (d2 > 1) begin
                        hx = scaled_heading(dx, d2, longint'(half_width));
                        hy = scaled_heading(dy, d2, longint'(half_width));
                    end
                end
                exp_pt.cx = cx;
                exp_pt.cy = cy;
                exp_pt.rx = SIDE_W'(longint'(cx) - longint'($signed(hy)));
                exp_pt.ry = SIDE_W'(longint'(cy) + longint'($signed(hx)));
                exp_pt.lx = SIDE_W'(longint'(cx) + longint'($signed(hy)));
                exp_pt.ly = SIDE_W'(longint'(cy) - longint'($signed(hx)));
                exp_pt.t  = i_time_ms;
                exp_pt.hx = hx;
                exp_pt.hy = hy;
                expected_points = {expected_points, exp_pt};
                prev_x    = cx;
                prev_y    = cy;
                have_prev = 1'b1;
            end
        end
        o_pending <= expected_points.size();
    end

endmodule

// ===== tb/sv/tb_path_side_point_generator_unit.sv =====
`timescale 1ns / 1ps

module tb_path_side_point_generator_unit;
    import pspg_pkg::*;

    // clock and reset
    logic                     i_clk   = 1'b0;
    logic                     i_rst_n = 1'b0;

    // half-width register port
    logic                     i_cfg_wr_en   = 1'b0;
    logic [HW_W-1:0]          i_cfg_wr_data = '0;

    // point channel
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic [CENTER_W-1:0]      i_center_x = '0;
    logic [CENTER_W-1:0]      i_center_y = '0;
    logic [TIME_W-1:0]        i_time_ms  = '0;
    logic                     i_restart  = 1'b0;

    // side point channel
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic [CENTER_W-1:0]      o_out_center_x;
    logic [CENTER_W-1:0]      o_out_center_y;
    logic signed [SIDE_W-1:0] o_right_x;
    logic signed [SIDE_W-1:0] o_right_y;
    logic signed [SIDE_W-1:0] o_left_x;
    logic signed [SIDE_W-1:0] o_left_y;
    logic [TIME_W-1:0]        o_out_time_ms;
    logic signed [HEAD_W-1:0] o_heading_x;
    logic signed [HEAD_W-1:0] o_heading_y;

    int                       fail_count;
    int                       pending;

    // idling on both sides is switched off for one long stretch
    bit                       idle_on = 1'b1;
    int                       stall_left = 0;

    // track generator state
    logic [CENTER_W-1:0]      track_x;
    logic [CENTER_W-1:0]      track_y;
    logic [TIME_W-1:0]        track_t;

    always #6 i_clk = ~i_clk;

    path_side_point_generator_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_center_x     (i_center_x),
        .i_center_y     (i_center_y),
        .i_time_ms      (i_time_ms),
        .i_restart      (i_restart),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_center_x (o_out_center_x),
        .o_out_center_y (o_out_center_y),
        .o_right_x      (o_right_x),
        .o_right_y      (o_right_y),
        .o_left_x       (o_left_x),
        .o_left_y       (o_left_y),
        .o_out_time_ms  (o_out_time_ms),
        .o_heading_x    (o_heading_x),
        .o_heading_y    (o_heading_y)
    );

    // predicts and checks every transaction on both channels
    pspg_side_point_checker side_point_chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_center_x     (i_center_x),
        .i_center_y     (i_center_y),
        .i_time_ms      (i_time_ms),
        .i_restart      (i_restart),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_out_center_x (o_out_center_x),
        .i_out_center_y (o_out_center_y),
        .i_right_x      (o_right_x),
        .i_right_y      (o_right_y),
        .i_left_x       (o_left_x),
        .i_left_y       (o_left_y),
        .i_out_time_ms  (o_out_time_ms),
        .i_heading_x    (o_heading_x),
        .i_heading_y    (o_heading_y),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // Receiver back-pressure: short bursts of ready low, about 8% of cycles.
    // Bursts land on any phase of the computation.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(99) < 2) begin
            stall_left  <= $urandom_range(6);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // One point transaction. Valid is only lowered when a gap is taken, so a
    // back-to-back point never sees valid dropped and raised in one step.
    task automatic send_point(input logic [CENTER_W-1:0] x, input logic [CENTER_W-1:0] y,
                              input logic [TIME_W-1:0] t, input logic rs);
        if (idle_on && $urandom_range(99) < 20) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_center_x <= x;
        i_center_y <= y;
        i_time_ms  <= t;
        i_restart  <= rs;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Waits until every predicted result has been seen. The do-while waits for
    // an edge before testing, so a point accepted at the current edge is counted.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // half-width write; only called with the block idle
    task automatic write_half_width(input logic [HW_W-1:0] hw);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= hw;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // Random track: mostly smooth motion with random content, plus tiny steps,
    // long jumps, restarts and fully random noise points.
    task automatic run_track(input int n_points);
        int  roll;
        int  dx;
        int  dy;
        logic rs;
        for (int i = 0; i < n_points; i++) begin
            roll = $urandom_range(99);
            rs   = 1'b0;
            dx   = 0;
            dy   = 0;
            if (roll < 5) begin
                rs      = 1'b1;
                track_x = CENTER_W'($urandom);
                track_y = CENTER_W'($urandom);
            end else if (roll < 12) begin
                rs      = 1'($urandom_range(1));
                track_x = CENTER_W'($urandom);
                track_y = CENTER_W'($urandom);
            end else if (roll < 22) begin
                // step of length at most one, or a near diagonal
                dx = int'($urandom_range(2)) - 1;
                dy = int'($urandom_range(2)) - 1;
            end else if (roll < 32) begin
                dx = int'($urandom_range(4095)) - 2048;
                dy = int'($urandom_range(4095)) - 2048;
            end else begin
                dx = int'($urandom_range(80)) - 40;
                dy = int'($urandom_range(80)) - 40;
            end
            track_x = track_x + dx[CENTER_W-1:0];
            track_y = track_y + dy[CENTER_W-1:0];
            if ($urandom_range(9) == 0)
                track_t = $urandom;
            else
                track_t = track_t + $urandom_range(1, 100);
            send_point(track_x, track_y, track_t, rs);
        end
    endtask

    initial begin
        track_x = '0;
        track_y = '0;
        track_t = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed points at the reset half-width of 50.
        send_point(12'd100, 12'd200, 32'h0000_0000, 1'b0);   // first point, no previous
        send_point(12'd100, 12'd200, 32'hFFFF_FFFF, 1'b0);   // zero step
        send_point(12'd101, 12'd200, 32'd1, 1'b0);           // unit step +x
        send_point(12'd101, 12'd201, 32'd2, 1'b0);           // unit step +y
        send_point(12'd100, 12'd201, 32'd3, 1'b0);           // unit step -x
        send_point(12'd100, 12'd200, 32'd4, 1'b0);           // unit step -y
        send_point(12'd101, 12'd201, 32'd5, 1'b0);           // diagonal, d2 = 2
        send_point(12'd0,   12'd0,   32'd6, 1'b0);           // negative step to origin
        send_point(12'd4095, 12'd4095, 32'd7, 1'b0);         // longest step
        send_point(12'd0,   12'd0,   32'd8, 1'b0);           // longest negative step
        send_point(12'd4095, 12'd0,  32'd9, 1'b0);           // pure +x
        send_point(12'd0,   12'd4095, 32'd10, 1'b0);         // both axes, side points off grid
        send_point(12'd4095, 12'd4095, 32'd11, 1'b1);        // restart after big step
        send_point(12'd4000, 12'd4095, 32'd12, 1'b0);        // pure -x
        send_point(12'd4095, 12'd4000, 32'd13, 1'b0);
        send_point(12'd2048, 12'd2048, 32'd14, 1'b1);        // restart mid-track
        send_point(12'd2348, 12'd2041, 32'd15, 1'b0);
        send_point(12'hAAA, 12'h555, 32'hAAAA_AAAA, 1'b0);   // alternating bit patterns
        send_point(12'h555, 12'hAAA, 32'h5555_5555, 1'b0);
        send_point(12'h555, 12'hAAA, 32'h8000_0000, 1'b1);   // restart on a zero step
        drain_results();

        // Largest half-width, starting from a fresh track.
        write_half_width(8'd255);
        send_point(12'd0, 12'd0, 32'd0, 1'b1);
        send_point(12'd0, 12'd4095, 32'd1, 1'b0);
        send_point(12'd4095, 12'd4095, 32'd2, 1'b0);
        send_point(12'd4094, 12'd4094, 32'd3, 1'b0);
        run_track(220);
        drain_results();

        // Smallest half-width.
        write_half_width(8'd1);
        run_track(220);
        drain_results();

        // Random half-width, long stretch with no idling on either side.
        idle_on = 1'b0;
        write_half_width(8'($urandom_range(1, 255)));
        run_track(230);
        drain_results();
        idle_on = 1'b1;

        write_half_width(8'd128);
        run_track(220);
        drain_results();

        write_half_width(8'($urandom_range(1, 255)));
        run_track(220);
        drain_results();

        write_half_width(8'd2);
        run_track(220);
        drain_results();

        // let any stray result show up before the verdict
        repeat (30) @(posedge i_clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Run limit: several times the slowest legal run.
    initial begin
        #8_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
